// File: sv/fqr_pkg.sv
package fqr_pkg;

  // operation codes carried by the mode field
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_REMOVE,
    S_DUMP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec_push;
    logic exec_remove;
    logic exec_dump;
  } cmd_t;

  // flags from datapath to controller
  typedef struct packed {
    logic out_free;
    logic store_empty;
    logic dump_last;
  } dp_flags_t;

endpackage

// File: sv/fqr_datapath.sv
module fqr_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  value,
  input  fqr_pkg::cmd_t       cmd,
  input  logic                out_ready,
  output fqr_pkg::dp_flags_t  flags,
  output logic                out_valid,
  output logic signed [31:0]  entry_value,
  output logic                last,
  output fqr_pkg::status_t    status
);
  import fqr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [DEPTH-1:0] ALL_ONES = '1;

  logic signed [31:0] entries [DEPTH];
  logic [CW-1:0]      count;
  logic signed [31:0] op_value;
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   match_next;
  logic [DEPTH-1:0]   shift_mask;
  logic [CW-1:0]      dump_idx;
  logic [CW-1:0]      count_m1;
  logic               full;
  logic               empty;
  logic               found;
  logic               out_free;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign found    = |match;
  assign count_m1 = count - CW'(1);
  assign out_free = !out_valid || out_ready;

  assign flags.out_free    = out_free;
  assign flags.store_empty = empty;
  assign flags.dump_last   = (dump_idx == count_m1);

  // parallel compare against live entries, and the gap mask from the first hit on
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign match_next[i] = (entries[i] == value) && (CW'(i) < count);
    assign shift_mask[i] = |(match & (ALL_ONES >> (DEPTH - 1 - i)));
  end

  // operand capture at accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_value <= value;
      match    <= match_next;
    end
  end

  // entry storage: append, close gap on remove, rotate on dump
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    if (i < DEPTH - 1) begin : g_inner
      always_ff @(posedge clk) begin
        if (cmd.exec_push && !full && (count == CW'(i))) begin
          entries[i] <= op_value;
        end else if (cmd.exec_remove && found && shift_mask[i]) begin
          entries[i] <= entries[i+1];
        end else if (cmd.exec_dump && (CW'(i) < count)) begin
          entries[i] <= (CW'(i) == count_m1) ? entries[0] : entries[i+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.exec_push && !full && (count == CW'(i))) begin
          entries[i] <= op_value;
        end else if (cmd.exec_dump && (CW'(i) < count)) begin
          entries[i] <= entries[0];
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec_push && !full) begin
      count <= count + CW'(1);
    end else if (cmd.exec_remove && found) begin
      count <= count_m1;
    end
  end

  // dump position
  always_ff @(posedge clk) begin
    if (rst) begin
      dump_idx <= '0;
    end else if (cmd.capture) begin
      dump_idx <= '0;
    end else if (cmd.exec_dump) begin
      dump_idx <= dump_idx + CW'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_push || cmd.exec_remove || cmd.exec_dump) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_push) begin
      entry_value <= '0;
      last        <= 1'b1;
      status      <= full ? ST_FULL : ST_OK;
    end else if (cmd.exec_remove) begin
      entry_value <= '0;
      last        <= 1'b1;
      if (empty) begin
        status <= ST_EMPTY;
      end else if (found) begin
        status <= ST_OK;
      end else begin
        status <= ST_NOT_FOUND;
      end
    end else if (cmd.exec_dump) begin
      if (empty) begin
        entry_value <= '0;
        last        <= 1'b1;
        status      <= ST_EMPTY;
      end else begin
        entry_value <= entries[0];
        last        <= flags.dump_last;
        status      <= ST_OK;
      end
    end
  end

endmodule

// File: sv/fqr_ctrl.sv
module fqr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         mode,
  input  fqr_pkg::dp_flags_t flags,
  output logic               in_ready,
  output fqr_pkg::cmd_t      cmd
);
  import fqr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            MODE_PUSH:   state_next = S_PUSH;
            MODE_REMOVE: state_next = S_REMOVE;
            MODE_DUMP:   state_next = S_DUMP;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_PUSH, S_REMOVE: begin
        if (flags.out_free) state_next = S_IDLE;
      end
      S_DUMP: begin
        if (flags.out_free && (flags.store_empty || flags.dump_last)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state == S_IDLE);
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.exec_push   = (state == S_PUSH) && flags.out_free;
    cmd.exec_remove = (state == S_REMOVE) && flags.out_free;
    cmd.exec_dump   = (state == S_DUMP) && flags.out_free;
  end

endmodule

// File: sv/fifo_queue_with_remove_by_value_top.sv
// push and remove: result word registered once the output register is free
// dump of N entries: one word per cycle while the output register is free;
//   the output register paces the rotation; a new request is taken only when idle
// remove compares all entries at accept and closes the gap when its result is registered
// reset clears the fill count, controller and output valid; entry storage is not cleared
module fifo_queue_with_remove_by_value_top #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  entry_value,
  output logic                last,
  output fqr_pkg::status_t    status
);
  import fqr_pkg::*;

  cmd_t      cmd;
  dp_flags_t flags;

  // sequencing
  fqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .flags    (flags),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // storage, compare and output register
  fqr_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .out_ready   (out_ready),
    .flags       (flags),
    .out_valid   (out_valid),
    .entry_value (entry_value),
    .last        (last),
    .status      (status)
  );

endmodule

// File: tb/fqr_queue_watch.sv
module fqr_queue_watch #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] entry_value,
  input  logic               last,
  input  fqr_pkg::status_t   status,
  output int                 mismatch_count,
  output int                 words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;
  import fqr_pkg::*;

  typedef struct packed {
    logic signed [31:0] entry_value;
    logic               last;
    status_t            status;
  } queue_word_t;

  // shadow of the stored values, head at index 0
  logic signed [31:0] stored_values[$];
  // words the block still owes, oldest first
  queue_word_t        owed_words[$];

  function automatic void owe_word(logic signed [31:0] v, logic l, status_t s);
    queue_word_t w;
    w.entry_value = v;
    w.last        = l;
    w.status      = s;
    owed_words.push_back(w);
  endfunction

  // update the shadow store and list the words one operation causes
  function automatic void apply_operation(logic [1:0] op, logic signed [31:0] operand);
    int hit;
    hit = -1;
    case (op)
      MODE_PUSH: begin
        if (stored_values.size() >= DEPTH) begin
          owe_word('0, 1'b1, ST_FULL);
        end else begin
          stored_values.push_back(operand);
          owe_word('0, 1'b1, ST_OK);
        end
      end
      MODE_REMOVE: begin
        if (stored_values.size() == 0) begin
          owe_word('0, 1'b1, ST_EMPTY);
        end else begin
          // first match from the head wins
          for (int i = 0; i < stored_values.size(); i++) begin
            if (hit < 0 && stored_values[i] == operand) hit = i;
          end
          if (hit < 0) begin
            owe_word('0, 1'b1, ST_NOT_FOUND);
          end else begin
            stored_values.delete(hit);
            owe_word('0, 1'b1, ST_OK);
          end
        end
      end
      MODE_DUMP: begin
        if (stored_values.size() == 0) begin
          owe_word('0, 1'b1, ST_EMPTY);
        end else begin
          for (int i = 0; i < stored_values.size(); i++) begin
            owe_word(stored_values[i], i == stored_values.size() - 1, ST_OK);
          end
        end
      end
      default: ;  // unused mode: no word, store unchanged
    endcase
  endfunction

  // compare outgoing words first, then predict for the incoming word
  always @(posedge clk) begin
    queue_word_t w;
    if (rst) begin
      stored_values.delete();
      owed_words.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected word value=%0d last=%0b status=%0d",
                     $realtime, entry_value, last, status);
          mismatch_count++;
        end else begin
          w = owed_words.pop_front();
          if (entry_value !== w.entry_value || last !== w.last || status !== w.status) begin
            if (mismatch_count < 10)
              $display("%0t: word differs: want value=%0d last=%0b status=%0d",
                       $realtime, w.entry_value, w.last, w.status,
                       ", got value=%0d last=%0b status=%0d",
                       entry_value, last, status);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_operation(mode, value);
    end
    words_in_flight = owed_words.size();
  end

endmodule

// File: tb/fifo_queue_with_remove_by_value_top_tb.sv
module fifo_queue_with_remove_by_value_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fqr_pkg::*;

  localparam int         DEPTH          = 32;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES    = 150;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         TAIL_CYCLES    = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         mode;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] entry_value;
  logic               last;
  status_t            status;

  int                 mismatch_count;
  int                 words_in_flight;
  int                 quiet_cycles;
  logic               quiet_tail;
  logic               hold_request;
  logic               hold_done;
  logic signed [31:0] value_pool[8];

  fifo_queue_with_remove_by_value_top #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_value(entry_value), .last(last), .status(status)
  );

  fqr_queue_watch #(.DEPTH(DEPTH)) watch (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_value(entry_value), .last(last), .status(status),
    .mismatch_count(mismatch_count), .words_in_flight(words_in_flight)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fifo_queue_with_remove_by_value_top: mismatch");
        $finish;
      end
    end
  end

  // output side: random stalls, calm stretches, one long hold-off
  initial begin
    int gap;
    int calm;
    gap       = 0;
    calm      = 0;
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done <= 1'b1;
      end else if (quiet_tail || calm > 0) begin
        out_ready <= 1'b1;
        if (calm > 0) calm--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else if ($urandom_range(0, 99) < 5) begin
        out_ready <= 1'b1;
        calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 7) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one word and hold it until accepted
  task automatic send_word(logic [1:0] op, logic signed [31:0] operand);
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= op;
    value    <= operand;
    do @(posedge clk); while (!in_ready);
  endtask

  // random sender gap with in_valid low, on a quarter of the calls outside the quiet tail
  task automatic sender_pause();
    int n;
    if (!quiet_tail && $urandom_range(0, 99) < 25) begin
      n = $urandom_range(1, 7);
      repeat (n) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  // mostly values from a small pool so removes find matches and duplicates
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_mode(int push_w, int remove_w, int dump_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) return MODE_PUSH;
    if (r < push_w + remove_w) return MODE_REMOVE;
    if (r < push_w + remove_w + dump_w) return MODE_DUMP;
    return MODE_UNUSED;
  endfunction

  task automatic random_phase(int count, int push_w, int remove_w, int dump_w);
    for (int i = 0; i < count; i++) begin
      send_word(pick_mode(push_w, remove_w, dump_w), pick_value());
      sender_pause();
    end
  endtask

  // stimulus and verdict
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_PUSH;
    value        = '0;
    quiet_tail   = 1'b0;
    hold_request = 1'b0;
    value_pool   = '{32'sh0, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
                     32'sd5, 32'sd17, 32'sh5555_5555, 32'shaaaa_aaaa};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty store cases
    send_word(MODE_DUMP, 32'sd99);
    send_word(MODE_REMOVE, 32'sd5);
    // extremes and duplicates
    send_word(MODE_PUSH, 32'sh7fff_ffff);
    send_word(MODE_PUSH, 32'sh8000_0000);
    send_word(MODE_PUSH, -32'sd1);
    send_word(MODE_PUSH, 32'sd0);
    send_word(MODE_PUSH, 32'sd7);
    send_word(MODE_PUSH, -32'sd1);
    send_word(MODE_PUSH, 32'sd7);
    send_word(MODE_DUMP, 32'sd0);
    // only the duplicate nearest the head goes
    send_word(MODE_REMOVE, 32'sd7);
    send_word(MODE_DUMP, -32'sd1);
    send_word(MODE_REMOVE, 32'sd1234);
    send_word(MODE_REMOVE, -32'sd1);
    send_word(MODE_UNUSED, 32'sh5a5a_a5a5);
    send_word(MODE_DUMP, 32'sd0);
    send_word(MODE_REMOVE, 32'sh8000_0000);
    send_word(MODE_REMOVE, 32'sh7fff_ffff);
    send_word(MODE_REMOVE, 32'sd0);
    send_word(MODE_REMOVE, 32'sd7);
    send_word(MODE_REMOVE, -32'sd1);
    send_word(MODE_DUMP, 32'sd0);

    // mixed traffic
    random_phase(40, 45, 30, 20);
    // fill to full while the output side holds off for a while
    hold_request = 1'b1;
    random_phase(50, 88, 4, 6);
    // drain with removes that mostly hit
    random_phase(35, 15, 70, 12);
    // last part with no idling on either side
    quiet_tail = 1'b1;
    random_phase(15, 40, 35, 20);

    @(negedge clk);
    in_valid <= 1'b0;
    while (words_in_flight != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("fifo_queue_with_remove_by_value_top: match");
    end else begin
      $display("fifo_queue_with_remove_by_value_top: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/fqr_pkg.sv
sv/fqr_datapath.sv
sv/fqr_ctrl.sv
sv/fifo_queue_with_remove_by_value_top.sv
tb/fqr_queue_watch.sv
tb/fifo_queue_with_remove_by_value_top_tb.sv
